FILE: sv/lsrc_pkg.sv
// Types, command and mode codes, and helper functions for the load-sense relay controller.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package lsrc_pkg;

	// Item commands.
	typedef enum logic [2:0] {
		CMD_SAMPLE    = 3'd0,
		CMD_SHORT_KEY = 3'd1,
		CMD_LONG_KEY  = 3'd2,
		CMD_TICK      = 3'd3,
		CMD_RESTART   = 3'd4
	} cmd_t;

	// Operating modes.
	typedef enum logic [1:0] {
		MODE_OFF  = 2'd0,
		MODE_ON   = 2'd1,
		MODE_AUTO = 2'd2
	} mode_t;

	// Configuration register indexes.
	localparam logic [1:0] CFG_THRESHOLD_HIGH  = 2'd0;
	localparam logic [1:0] CFG_KEEP_ON_SECONDS = 2'd1;
	localparam logic [1:0] CFG_START_IN_AUTO   = 2'd2;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Hysteresis between the high and low thresholds, in watts.
	localparam logic [15:0] HYSTERESIS_W = 16'd20;
	// Power samples per second.
	localparam logic [8:0] SAMPLES_PER_SECOND = 9'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [15:0] power_watts;
	} item_t;

	typedef struct packed {
		logic       relay_closed;
		logic       mode_led_lit;
		logic [1:0] current_mode;
		logic       load_detected;
	} result_t;

	// Increment that sticks at the top of an 8-bit counter.
	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

endpackage

`default_nettype wire

FILE: sv/load_sense_relay_controller.sv
// Top level of the load-sense relay controller: input register, event logic, result register.
// Depends on lsrc_pkg for the item, result, command and mode types.
//
// Usage. Events arrive on the item channel (item_valid, item_ready, item): power samples,
// short and long key presses, timer ticks and restart commands. Every accepted item gives
// exactly one result on the result channel (result_valid, result_ready, result) that shows
// the relay drive, the mode LED, the current mode and the qualified load status after the
// event. The three configuration registers are written on the cfg channel, which is always
// ready; writes are expected only while no item is in flight.
//
// Pipeline. An item is captured in the input register on the transfer, and its result is
// loaded into the result register when that register is empty or its result is being taken.
// One item is taken every cycle while results are taken: the event logic is a single pass of
// compares and 8-bit counter increments between the two registers.
//
// Stalls. If result_ready stays low, the result register holds its item, the input register
// holds the next one, and item_ready falls only when both are full. No result is lost.
//
// Reset. arst_n clears the registers, the mode (off), the detector, all counters, the relay
// and the LED, and empties both pipeline registers.
`default_nettype none

module load_sense_relay_controller #(
	parameter int unsigned ON_RUN_LIMIT = 2,
	parameter int unsigned BLINK_PERIOD = 6,
	parameter int unsigned PRESCALE_TOP = 10
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           item_valid,
	output logic                          item_ready,
	input  wire lsrc_pkg::item_t          item,
	output logic                          result_valid,
	input  wire                           result_ready,
	output lsrc_pkg::result_t             result,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire [lsrc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire [lsrc_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lsrc_pkg::*;

	localparam logic [7:0] ON_LIMIT8 = 8'(ON_RUN_LIMIT);
	localparam logic [7:0] BLINK8    = 8'(BLINK_PERIOD);
	localparam logic [7:0] PRESC8    = 8'(PRESCALE_TOP);

	// Configuration registers.
	logic [15:0] threshold_high_q;
	logic [5:0]  keep_on_seconds_q;
	logic        start_in_auto_q;

	// Controller state.
	mode_t      op_mode_q,   mode_n;
	logic       load_q,      load_n;
	logic [7:0] above_q,     above_n;
	logic [7:0] below_q,     below_n;
	logic       relay_q,     relay_n;
	logic       led_q,       led_n;
	logic [7:0] phase_q,     phase_n;
	logic [7:0] presc_q,     presc_n;

	// Pipeline.
	item_t   item_s1;
	logic    valid_s1;
	result_t result_q;
	logic    result_valid_q;

	logic        advance;
	logic        step;
	logic [15:0] low_thresh;
	logic [8:0]  off_full;
	logic [7:0]  off_count;

	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || result_ready;
	assign item_ready   = !valid_s1 || advance;
	assign step         = valid_s1 && advance;
	assign result       = result_q;
	assign result_valid = result_valid_q;

	// Low threshold saturates at zero; the off count saturates at the counter's top.
	assign low_thresh = (threshold_high_q >= HYSTERESIS_W) ? threshold_high_q - HYSTERESIS_W
		: 16'd0;
	assign off_full   = 9'(keep_on_seconds_q) * SAMPLES_PER_SECOND;
	assign off_count  = (off_full > 9'd255) ? 8'hFF : off_full[7:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_high_q  <= '0;
			keep_on_seconds_q <= '0;
			start_in_auto_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_addr)
				CFG_THRESHOLD_HIGH:  threshold_high_q  <= cfg_data;
				CFG_KEEP_ON_SECONDS: keep_on_seconds_q <= cfg_data[5:0];
				CFG_START_IN_AUTO:   start_in_auto_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Next state for the item in the input register.
	always_comb begin
		mode_n  = op_mode_q;
		load_n  = load_q;
		above_n = above_q;
		below_n = below_q;
		relay_n = relay_q;
		led_n   = led_q;
		phase_n = phase_q;
		presc_n = presc_q;
		case (item_s1.command)
			CMD_SAMPLE: begin
				// The turn-on rule goes first; the turn-off rule sees its outcome.
				if (!load_q && item_s1.power_watts >= threshold_high_q) begin
					below_n = 8'd0;
					above_n = sat_inc(above_q);
					if (above_n > ON_LIMIT8) begin
						load_n = 1'b1;
					end
				end
				if (load_n && item_s1.power_watts <= low_thresh) begin
					above_n = 8'd0;
					below_n = sat_inc(below_n);
					if (below_n > off_count) begin
						load_n = 1'b0;
					end
				end
				case (op_mode_q)
					MODE_ON:   relay_n = 1'b1;
					MODE_AUTO: relay_n = load_n;
					default:   relay_n = 1'b0;
				endcase
			end
			CMD_SHORT_KEY: begin
				mode_n = (op_mode_q == MODE_OFF) ? MODE_ON : MODE_OFF;
			end
			CMD_LONG_KEY: begin
				mode_n = (op_mode_q == MODE_AUTO) ? MODE_ON : MODE_AUTO;
			end
			CMD_TICK: begin
				presc_n = sat_inc(presc_q);
				if (presc_n > PRESC8) begin
					presc_n = 8'd0;
					if (op_mode_q == MODE_AUTO) begin
						if (phase_q == 8'd0) begin
							led_n = !led_q;
						end
						phase_n = sat_inc(phase_q);
						if (phase_n > BLINK8) begin
							phase_n = 8'd0;
						end
					end else begin
						led_n   = (op_mode_q == MODE_ON);
						phase_n = 8'd0;
					end
				end
			end
			CMD_RESTART: begin
				// The tick prescaler runs free and is left alone here.
				relay_n = 1'b0;
				led_n   = 1'b0;
				mode_n  = start_in_auto_q ? MODE_AUTO : MODE_OFF;
				load_n  = 1'b0;
				above_n = 8'd0;
				below_n = 8'd0;
				phase_n = 8'd0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= MODE_OFF;
			load_q    <= 1'b0;
			above_q   <= '0;
			below_q   <= '0;
			relay_q   <= 1'b0;
			led_q     <= 1'b0;
			phase_q   <= '0;
			presc_q   <= '0;
		end else if (step) begin
			op_mode_q <= mode_n;
			load_q    <= load_n;
			above_q   <= above_n;
			below_q   <= below_n;
			relay_q   <= relay_n;
			led_q     <= led_n;
			phase_q   <= phase_n;
			presc_q   <= presc_n;
		end
	end

	// Valid flags of the input and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_ready) begin
				valid_s1 <= item_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (step) begin
			result_q.relay_closed  <= relay_n;
			result_q.mode_led_lit  <= led_n;
			result_q.current_mode  <= mode_n;
			result_q.load_detected <= load_n;
		end
	end

	// Load detection only turns on as the result of a power sample.
	a_load_on_by_sample: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(load_q) |-> $past(step) && $past(item_s1.command) == CMD_SAMPLE)
		else $error("load status rose without a power sample");

	// The prescaler wraps before passing its top value.
	a_presc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		presc_q <= PRESC8)
		else $error("tick prescaler beyond its top");

	// The blink phase stays within its period.
	a_phase_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= BLINK8)
		else $error("blink phase beyond its period");

	// The mode changes only when an item is processed.
	a_mode_on_step: assert property (@(posedge clk) disable iff (!arst_n)
		op_mode_q != $past(op_mode_q) |-> $past(step))
		else $error("mode changed without an item");

endmodule

`default_nettype wire
